// ===== hdl/lci_pkg.sv =====
// Shared types and constants for the line/circle intersection unit.
`timescale 1ns / 1ps
package lci_pkg;

  localparam int TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;
  localparam int KIND_WIDTH = 2;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_NONE,
    KIND_VERT,
    KIND_QUAD
  } kind_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

endpackage

// ===== hdl/lci_fifo.sv =====
// Small word queue between the classifying front end and the solver.
`timescale 1ns / 1ps
module lci_fifo #(
  parameter int WIDTH = 193,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

// ===== hdl/lci_front.sv =====
// Input stage: take a word, classify the line and queue it for the solver.
`timescale 1ns / 1ps
module lci_front #(
  parameter int CW = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [6*CW-2:0]                     in_item,
  input  logic [lci_pkg::TOL_WIDTH-1:0]       tol,
  output logic                                push,
  output logic [6*CW-2+lci_pkg::KIND_WIDTH:0] push_word,
  input  logic                                q_full
);
  logic                   v_r;
  logic [6*CW-2:0]        item_r;
  lci_pkg::kind_t         kind_r;
  logic signed [CW-1:0]   a, b;
  logic [CW-1:0]          absb;
  logic                   vert;
  lci_pkg::kind_t         kind;

  assign a    = in_item[CW-1:0];
  assign b    = in_item[2*CW-1:CW];
  assign absb = b[CW-1] ? (~b + CW'(1)) : b;
  assign vert = (absb < CW'(tol)) || (b == '0);

  always_comb begin
    priority if (a == '0 && b == '0) begin
      kind = lci_pkg::KIND_NONE;
    end else if (vert && a == '0) begin
      kind = lci_pkg::KIND_NONE;
    end else if (vert) begin
      kind = lci_pkg::KIND_VERT;
    end else begin
      kind = lci_pkg::KIND_QUAD;
    end
  end

  assign in_ready  = !v_r || !q_full;
  assign push      = v_r && !q_full;
  assign push_word = {kind_r, item_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (push) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
      kind_r <= kind;
    end
  end
endmodule

// ===== hdl/lci_arith.sv =====
// Shared multi-cycle unit: shift-add multiply, restoring floor divide, square root.
`timescale 1ns / 1ps
module lci_arith #(
  parameter int DW       = 256,
  parameter int SQ_STEPS = 68
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lci_pkg::arith_ctl_t ctl,
  input  logic [DW-1:0]       opx,
  input  logic [DW-1:0]       opy,
  output logic                done,
  output logic [DW-1:0]       res
);
  localparam int CNTW = $clog2(DW + 1);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_SQRT} ust_t;

  ust_t            st_r;
  logic [DW-1:0]   wa_r, wb_r, wc_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DW-1:0]   res_r;
  logic [DW-1:0]   div_rt, sq_rt, sq_tr;
  logic            div_ge, sq_ge;

  assign div_rt = {wa_r[DW-2:0], wb_r[DW-1]};
  assign div_ge = (div_rt >= wc_r);
  assign sq_rt  = {wa_r[DW-3:0], wb_r[DW-1:DW-2]};
  assign sq_tr  = {wc_r[DW-3:0], 2'b01};
  assign sq_ge  = (sq_rt >= sq_tr);
  assign done   = done_r;
  assign res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (ctl.start) begin
            wa_r <= '0;
            unique case (ctl.op)
              lci_pkg::OP_MUL: begin
                wb_r  <= opx;
                wc_r  <= opy[DW-1] ? (~opy + DW'(1)) : opy;
                neg_r <= opy[DW-1];
                st_r  <= U_MUL;
              end
              lci_pkg::OP_DIV: begin
                wb_r  <= opx[DW-1] ? (~opx + DW'(1)) : opx;
                wc_r  <= opy;
                neg_r <= opx[DW-1];
                cnt_r <= CNTW'(DW);
                st_r  <= U_DIV;
              end
              lci_pkg::OP_SQRT: begin
                wb_r  <= opx << (DW - 2 * SQ_STEPS);
                wc_r  <= '0;
                cnt_r <= CNTW'(SQ_STEPS);
                st_r  <= U_SQRT;
              end
              default: begin
                st_r <= U_IDLE;
              end
            endcase
          end
        end
        U_MUL: begin
          if (wc_r == '0) begin
            res_r  <= neg_r ? (~wa_r + DW'(1)) : wa_r;
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end else begin
            if (wc_r[0]) begin
              wa_r <= wa_r + wb_r;
            end
            wb_r <= {wb_r[DW-2:0], 1'b0};
            wc_r <= {1'b0, wc_r[DW-1:1]};
          end
        end
        U_DIV: begin
          if (cnt_r == '0) begin
            res_r  <= !neg_r ? wb_r : ((wa_r != '0) ? ~wb_r : (~wb_r + DW'(1)));
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end else begin
            wa_r  <= div_ge ? (div_rt - wc_r) : div_rt;
            wb_r  <= {wb_r[DW-2:0], div_ge};
            cnt_r <= cnt_r - CNTW'(1);
          end
        end
        U_SQRT: begin
          if (cnt_r == '0) begin
            res_r  <= wc_r;
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end else begin
            wa_r  <= sq_ge ? (sq_rt - sq_tr) : sq_rt;
            wc_r  <= {wc_r[DW-2:0], sq_ge};
            wb_r  <= {wb_r[DW-3:0], 2'b00};
            cnt_r <= cnt_r - CNTW'(1);
          end
        end
        default: begin
          st_r <= U_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hdl/lci_back.sv =====
// Solver: sequences the shared arithmetic unit and drives the result register.
`timescale 1ns / 1ps
module lci_back #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int DW = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  logic [6*CW-2+lci_pkg::KIND_WIDTH:0] q_word,
  output logic                                q_pop,
  input  logic [lci_pkg::TOL_WIDTH-1:0]       tol,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [CW-1:0]                       out_x,
  output logic [CW-1:0]                       out_y,
  output logic [1:0]                          out_found,
  output logic                                out_last
);
  typedef enum logic [4:0] {
    S_IDLE, S_V_DIV, S_V_CHK, S_V_RR, S_V_DD, S_V_SQ,
    S_Q_AA, S_Q_BB, S_Q_ACX, S_Q_BCY, S_Q_RR, S_Q_AR, S_Q_CC, S_Q_DI,
    S_Q_P, S_Q_M, S_Q_CHK, S_Q_XT, S_Q_YT, S_Q_SQ, S_Q_Q, S_Q_SA,
    S_Q_X1, S_Q_Y1, S_Q_X2, S_Q_Y2, S_EMIT0, S_EMIT1
  } state_t;

  state_t               state_r;
  logic                 issued_r;
  lci_pkg::arith_ctl_t  ctl_r;
  logic signed [DW-1:0] a_r, b_r, c_r, cx_r, cy_r, rad_r;
  logic signed [DW-1:0] t1_r, t2_r, bb_r, a2_r, c2_r, e_r, p_r, m_r, s_r, q_r, sa_r;
  logic signed [DW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [1:0]           found_r;
  logic                 two_r;
  logic                 out_valid_r, out_last_r;
  logic [CW-1:0]        out_x_r, out_y_r;
  logic [1:0]           out_found_r;

  lci_pkg::arith_op_t   op;
  logic signed [DW-1:0] opx, opy;
  logic                 compute;
  logic                 u_done;
  logic signed [DW-1:0] u_res;
  logic signed [DW-1:0] cshift, dx, absdx, d1, d2, absd1, absd2, tolx, absdi, th, absb;
  logic                 slot_free;
  lci_pkg::kind_t       q_kind;
  logic [CW-1:0]        f_a, f_b, f_c, f_cx, f_cy;
  logic [CW-2:0]        f_r;

  function automatic logic [CW-1:0] sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi, lo;
    hi = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[CW-1:0];
    end else if (v < lo) begin
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  assign f_a    = q_word[CW-1:0];
  assign f_b    = q_word[2*CW-1:CW];
  assign f_c    = q_word[3*CW-1:2*CW];
  assign f_cx   = q_word[4*CW-1:3*CW];
  assign f_cy   = q_word[5*CW-1:4*CW];
  assign f_r    = q_word[6*CW-2:5*CW];
  assign q_kind = lci_pkg::kind_t'(q_word[6*CW-2+lci_pkg::KIND_WIDTH -: lci_pkg::KIND_WIDTH]);

  assign cshift = c_r <<< FB;
  assign dx     = x0_r - cx_r;
  assign absdx  = dx[DW-1] ? -dx : dx;
  assign d1     = dx - rad_r;
  assign d2     = dx + rad_r;
  assign absd1  = d1[DW-1] ? -d1 : d1;
  assign absd2  = d2[DW-1] ? -d2 : d2;
  assign tolx   = {{(DW-lci_pkg::TOL_WIDTH){1'b0}}, tol};
  assign th     = tolx <<< (5 * FB);
  assign absdi  = t1_r[DW-1] ? -t1_r : t1_r;
  assign absb   = b_r[DW-1] ? -b_r : b_r;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign compute   = !(state_r == S_IDLE || state_r == S_V_CHK || state_r == S_Q_CHK ||
                       state_r == S_EMIT0 || state_r == S_EMIT1);

  always_comb begin
    op  = lci_pkg::OP_MUL;
    opx = a_r;
    opy = a_r;
    unique case (state_r)
      S_V_DIV: begin
        op  = lci_pkg::OP_DIV;
        opx = a_r[DW-1] ? cshift : -cshift;
        opy = a_r[DW-1] ? -a_r : a_r;
      end
      S_V_RR:  begin opx = rad_r; opy = rad_r; end
      S_V_DD:  begin opx = dx;    opy = dx;    end
      S_V_SQ:  begin op = lci_pkg::OP_SQRT; opx = t1_r - t2_r; end
      S_Q_AA:  begin opx = a_r;   opy = a_r;   end
      S_Q_BB:  begin opx = b_r;   opy = b_r;   end
      S_Q_ACX: begin opx = cx_r;  opy = a_r;   end
      S_Q_BCY: begin opx = cy_r;  opy = b_r;   end
      S_Q_RR:  begin opx = rad_r; opy = rad_r; end
      S_Q_AR:  begin opx = a2_r;  opy = t1_r;  end
      S_Q_CC:  begin opx = c2_r;  opy = c2_r;  end
      S_Q_DI:  begin opx = e_r;   opy = bb_r;  end
      S_Q_P:   begin opx = c2_r;  opy = a_r;   end
      S_Q_M:   begin opx = c2_r;  opy = b_r;   end
      S_Q_XT:  begin op = lci_pkg::OP_DIV; opx = -p_r; opy = a2_r; end
      S_Q_YT:  begin op = lci_pkg::OP_DIV; opx = -m_r; opy = a2_r; end
      S_Q_SQ:  begin op = lci_pkg::OP_SQRT; opx = e_r; end
      S_Q_Q:   begin opx = s_r;   opy = absb;  end
      S_Q_SA:  begin opx = s_r;   opy = a_r;   end
      S_Q_X1:  begin op = lci_pkg::OP_DIV; opx = q_r - p_r;      opy = a2_r; end
      S_Q_Y1:  begin op = lci_pkg::OP_DIV; opx = -(m_r + sa_r);  opy = a2_r; end
      S_Q_X2:  begin op = lci_pkg::OP_DIV; opx = -(p_r + q_r);   opy = a2_r; end
      S_Q_Y2:  begin op = lci_pkg::OP_DIV; opx = sa_r - m_r;     opy = a2_r; end
      default: begin
        op = lci_pkg::OP_MUL;
      end
    endcase
  end

  lci_arith #(
    .DW       (DW),
    .SQ_STEPS (2 * CW + 4)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r),
    .opx   (opx),
    .opy   (opy),
    .done  (u_done),
    .res   (u_res)
  );

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r.start <= 1'b0;
      ctl_r.op    <= op;
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (compute && !issued_r) begin
        ctl_r.start <= 1'b1;
        issued_r    <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            a_r   <= {{(DW-CW){f_a[CW-1]}}, f_a};
            b_r   <= {{(DW-CW){f_b[CW-1]}}, f_b};
            c_r   <= {{(DW-CW){f_c[CW-1]}}, f_c};
            cx_r  <= {{(DW-CW){f_cx[CW-1]}}, f_cx};
            cy_r  <= {{(DW-CW){f_cy[CW-1]}}, f_cy};
            rad_r <= {{(DW-CW+1){1'b0}}, f_r};
            unique case (q_kind)
              lci_pkg::KIND_VERT: state_r <= S_V_DIV;
              lci_pkg::KIND_QUAD: state_r <= S_Q_AA;
              default: begin
                x0_r    <= '0;
                y0_r    <= '0;
                found_r <= 2'd0;
                two_r   <= 1'b0;
                state_r <= S_EMIT0;
              end
            endcase
          end
        end
        S_V_CHK: begin
          if (absdx > rad_r) begin
            x0_r    <= '0;
            y0_r    <= '0;
            found_r <= 2'd0;
            two_r   <= 1'b0;
            state_r <= S_EMIT0;
          end else if (absd1 < tolx || absd2 < tolx) begin
            y0_r    <= cy_r;
            found_r <= 2'd1;
            two_r   <= 1'b0;
            state_r <= S_EMIT0;
          end else begin
            state_r <= S_V_RR;
          end
        end
        S_Q_CHK: begin
          if (absdi < th) begin
            state_r <= S_Q_XT;
          end else if (e_r[DW-1]) begin
            x0_r    <= '0;
            y0_r    <= '0;
            found_r <= 2'd0;
            two_r   <= 1'b0;
            state_r <= S_EMIT0;
          end else begin
            state_r <= S_Q_SQ;
          end
        end
        S_EMIT0: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= sat(x0_r);
            out_y_r     <= sat(y0_r);
            out_found_r <= found_r;
            out_last_r  <= !two_r;
            state_r     <= two_r ? S_EMIT1 : S_IDLE;
          end
        end
        S_EMIT1: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= sat(x1_r);
            out_y_r     <= sat(y1_r);
            out_found_r <= found_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          if (issued_r && u_done) begin
            issued_r <= 1'b0;
            unique case (state_r)
              S_V_DIV: begin x0_r <= u_res; state_r <= S_V_CHK; end
              S_V_RR:  begin t1_r <= u_res; state_r <= S_V_DD;  end
              S_V_DD:  begin t2_r <= u_res; state_r <= S_V_SQ;  end
              S_V_SQ: begin
                y0_r    <= cy_r + u_res;
                y1_r    <= cy_r - u_res;
                x1_r    <= x0_r;
                found_r <= 2'd2;
                two_r   <= 1'b1;
                state_r <= S_EMIT0;
              end
              S_Q_AA:  begin t1_r <= u_res; state_r <= S_Q_BB; end
              S_Q_BB:  begin bb_r <= u_res; state_r <= S_Q_ACX; end
              S_Q_ACX: begin
                t2_r    <= u_res;
                a2_r    <= t1_r + bb_r;
                state_r <= S_Q_BCY;
              end
              S_Q_BCY: begin c2_r <= cshift + t2_r + u_res; state_r <= S_Q_RR; end
              S_Q_RR:  begin t1_r <= u_res; state_r <= S_Q_AR; end
              S_Q_AR:  begin t1_r <= u_res; state_r <= S_Q_CC; end
              S_Q_CC:  begin e_r <= t1_r - u_res; state_r <= S_Q_DI; end
              S_Q_DI:  begin t1_r <= u_res <<< 2; state_r <= S_Q_P; end
              S_Q_P:   begin p_r <= u_res; state_r <= S_Q_M; end
              S_Q_M:   begin m_r <= u_res; state_r <= S_Q_CHK; end
              S_Q_XT:  begin x0_r <= cx_r + u_res; state_r <= S_Q_YT; end
              S_Q_YT: begin
                y0_r    <= cy_r + u_res;
                found_r <= 2'd1;
                two_r   <= 1'b0;
                state_r <= S_EMIT0;
              end
              S_Q_SQ:  begin s_r <= u_res; state_r <= S_Q_Q; end
              S_Q_Q:   begin q_r <= u_res; state_r <= S_Q_SA; end
              S_Q_SA:  begin sa_r <= b_r[DW-1] ? -u_res : u_res; state_r <= S_Q_X1; end
              S_Q_X1:  begin x0_r <= cx_r + u_res; state_r <= S_Q_Y1; end
              S_Q_Y1:  begin y0_r <= cy_r + u_res; state_r <= S_Q_X2; end
              S_Q_X2:  begin x1_r <= cx_r + u_res; state_r <= S_Q_Y2; end
              S_Q_Y2: begin
                y1_r    <= cy_r + u_res;
                found_r <= 2'd2;
                two_r   <= 1'b1;
                state_r <= S_EMIT0;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end
endmodule

// ===== hdl/line_circle_intersection_unit.sv =====
// Top level: tolerance register, front end, word queue and solver.
`timescale 1ns / 1ps
// Throughput: one item per solve time; the bit-serial multiply, divide and
//   square root unit is shared by all steps and sets that figure.
// The front end takes a word per cycle until the four-deep queue fills.
// Reset clears all handshake state and loads the tolerance with 7.
module line_circle_intersection_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // line_a, line_b, line_c, center_x, center_y, radius; zero padded
  input  logic [((6*COORD_WIDTH-1+7)/8)*8-1:0] in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // point_x, point_y, found; zero padded
  output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [lci_pkg::TOL_WIDTH-1:0]       cfg_wdata
);
  localparam int CW  = COORD_WIDTH;
  localparam int DW  = 6 * CW + 2 * FRAC_BITS + 16;
  localparam int QW  = 6 * CW - 1 + lci_pkg::KIND_WIDTH;
  localparam int OW  = ((2 * CW + 2 + 7) / 8) * 8;

  logic [lci_pkg::TOL_WIDTH-1:0] tol_r;
  logic                          push, q_full, q_empty, q_pop;
  logic [QW-1:0]                 push_word, q_word;
  logic [CW-1:0]                 px, py;
  logic [1:0]                    found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= lci_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  lci_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_tdata[6*CW-2:0]),
    .tol       (tol_r),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full)
  );

  lci_fifo #(.WIDTH(QW), .DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_word),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_word),
    .empty (q_empty)
  );

  lci_back #(.CW(CW), .FB(FRAC_BITS), .DW(DW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .tol       (tol_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (px),
    .out_y     (py),
    .out_found (found),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OW-2*CW-2){1'b0}}, found, py, px};
endmodule

// ===== dv/line_circle_intersection_unit_test.sv =====
// Self-checking stream testbench for the line/circle intersection unit.
`timescale 1ns / 1ps
module line_circle_intersection_unit_test;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        r;
  } query_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  found;
    logic        last;
  } point_t;

  localparam logic [1:0] FOUND_NONE = 2'd0;
  localparam logic [1:0] FOUND_ONE  = 2'd1;
  localparam logic [1:0] FOUND_TWO  = 2'd2;
  localparam wide_t COORD_MAX = 256'sh7fffffff;
  localparam wide_t COORD_MIN = -COORD_MAX - 1;
  localparam int SOLVE_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [lci_pkg::TOL_WIDTH-1:0] cfg_wdata = '0;

  query_t pending_queries[$];
  point_t expected_points[$];
  query_t cur_query;
  logic [lci_pkg::TOL_WIDTH-1:0] tol_mirror = lci_pkg::TOL_RESET;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int n_queries = 0;
  int n_points = 0;
  int n_none = 0;
  int n_tangent = 0;
  int n_pairs = 0;
  int n_errors = 0;

  line_circle_intersection_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic wide_t int_sqrt(wide_t n);
    wide_t res;
    wide_t cand;
    res = 0;
    for (int i = 67; i >= 0; i--) begin
      cand = res | (wide_t'(1) <<< i);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_coord(wide_t v);
    if (v > COORD_MAX) return 32'h7fffffff;
    if (v < COORD_MIN) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic wide_t abs_w(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void add_query(query_t q);
    pending_queries.insert(pending_queries.size(), q);
  endfunction

  function automatic void push_point(wide_t x, wide_t y, logic [1:0] f, logic l);
    point_t p;
    p.x = clamp_coord(x);
    p.y = clamp_coord(y);
    p.found = f;
    p.last = l;
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic void push_none();
    point_t p;
    p = '{32'd0, 32'd0, FOUND_NONE, 1'b1};
    expected_points.insert(expected_points.size(), p);
    n_none++;
  endfunction

  function automatic void predict_points(query_t q, logic [lci_pkg::TOL_WIDTH-1:0] tol);
    wide_t a, b, c, cx, cy, r, t, n, vx, dx, dy;
    wide_t a2, c2, e, di, th, p, m, s, qq, sa;
    a = wide_t'(q.a); b = wide_t'(q.b); c = wide_t'(q.c);
    cx = wide_t'(q.cx); cy = wide_t'(q.cy);
    r = {225'd0, q.r};
    t = {240'd0, tol};
    if (a == 0 && b == 0) begin
      push_none();
    end else if (abs_w(b) < t || b == 0) begin
      n = c <<< 16;
      if (a == 0) begin
        push_none();
      end else begin
        vx = (a > 0) ? floor_div(-n, a) : floor_div(n, -a);
        dx = vx - cx;
        if (abs_w(dx) > r) begin
          push_none();
        end else if (abs_w(dx - r) < t || abs_w(dx + r) < t) begin
          push_point(vx, cy, FOUND_ONE, 1'b1);
          n_tangent++;
        end else begin
          dy = int_sqrt(r * r - dx * dx);
          push_point(vx, cy + dy, FOUND_TWO, 1'b0);
          push_point(vx, cy - dy, FOUND_TWO, 1'b1);
          n_pairs++;
        end
      end
    end else begin
      a2 = a * a + b * b;
      c2 = (c <<< 16) + a * cx + b * cy;
      e = a2 * r * r - c2 * c2;
      di = (b * b * e) <<< 2;
      th = t <<< 80;
      p = a * c2;
      m = b * c2;
      if (abs_w(di) < th) begin
        push_point(cx + floor_div(-p, a2), cy + floor_div(-m, a2), FOUND_ONE, 1'b1);
        n_tangent++;
      end else if (e < 0) begin
        push_none();
      end else begin
        s = int_sqrt(e);
        qq = abs_w(b) * s;
        sa = a * s;
        if (b < 0) sa = -sa;
        push_point(cx + floor_div(qq - p, a2), cy + floor_div(-(m + sa), a2), FOUND_TWO, 1'b0);
        push_point(cx + floor_div(-(p + qq), a2), cy + floor_div(sa - m, a2), FOUND_TWO, 1'b1);
        n_pairs++;
      end
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // Sender: present one query word at a time, predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_points(cur_query, tol_mirror);
        n_queries++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_queries.size() > 0) begin
          cur_query = pending_queries.pop_front();
          in_tdata <= {1'b0, cur_query.r, cur_query.cy, cur_query.cx,
                       cur_query.c, cur_query.b, cur_query.a};
          in_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus one long hold-off to fill the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && n_queries >= 60) begin
        hold_done = 1;
        hold_left = 12 * SOLVE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Monitor: compare each result word against the oldest prediction.
  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_points++;
      if (expected_points.size() == 0) begin
        $error("unexpected result word x=%h y=%h", out_tdata[31:0], out_tdata[63:32]);
        n_errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[31:0] !== want.x) begin
          $error("point_x expected %h actual %h", want.x, out_tdata[31:0]);
          n_errors++;
        end
        if (out_tdata[63:32] !== want.y) begin
          $error("point_y expected %h actual %h", want.y, out_tdata[63:32]);
          n_errors++;
        end
        if (out_tdata[65:64] !== want.found) begin
          $error("found expected %0d actual %0d", want.found, out_tdata[65:64]);
          n_errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_coef();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic query_t make_query(int a, int b, int c, int cx, int cy, int r);
    query_t q;
    q.a = a; q.b = b; q.c = c; q.cx = cx; q.cy = cy; q.r = r[30:0];
    return q;
  endfunction

  // Line through a point near the circle, so all three outcomes show up.
  function automatic query_t near_query(logic [lci_pkg::TOL_WIDTH-1:0] tol);
    query_t q;
    logic signed [63:0] px, py, acc, rs;
    int roll;
    roll = $urandom_range(0, 99);
    q.cx = $signed($urandom) >>> $urandom_range(4, 16);
    q.cy = $signed($urandom) >>> $urandom_range(4, 16);
    q.r = 31'($urandom_range(1, 32'h00ffffff) >> $urandom_range(0, 10));
    q.a = rand_coef();
    if (roll < 20) q.b = $signed($urandom_range(0, tol)) * ($urandom_range(0, 1) ? 1 : -1);
    else q.b = rand_coef();
    rs = $signed({33'd0, q.r});
    px = q.cx + $signed(64'($urandom_range(0, 2 * q.r))) - rs;
    py = q.cy + $signed(64'($urandom_range(0, 2 * q.r))) - rs;
    if (roll >= 20 && roll < 30) begin
      // line through a point with x = cx +/- r
      px = q.cx + (($urandom_range(0, 1)) ? rs : -rs);
    end
    acc = q.a * px + q.b * py;
    q.c = 32'(-(acc >>> 16));
    return q;
  endfunction

  function automatic query_t noise_query();
    query_t q;
    q.a = $urandom; q.b = $urandom; q.c = $urandom;
    q.cx = $urandom; q.cy = $urandom; q.r = 31'($urandom);
    return q;
  endfunction

  task automatic write_tolerance(logic [lci_pkg::TOL_WIDTH-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tol_mirror = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_queries.size() != 0 || in_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (SOLVE_CYCLES) @(posedge clk);
  endtask

  task automatic load_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 80) add_query(near_query(tol_mirror));
      else add_query(noise_query());
    end
  endtask

  initial begin
    logic [lci_pkg::TOL_WIDTH-1:0] tol_set[4];
    tol_set = '{16'd0, 16'hffff, 16'd7, 16'd0};
    tol_set[3] = 16'($urandom_range(1, 16'hfffe));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // degenerate, vertical, tangent, two points, none, saturation
    add_query(make_query(0, 0, 65536, 0, 0, 65536));
    add_query(make_query(0, 3, 0, 0, 0, 65536));
    add_query(make_query(65536, 0, 0, 0, 0, 65536));
    add_query(make_query(65536, 0, -65536, 0, 0, 65536));
    add_query(make_query(65536, 0, -5 * 65536, 0, 0, 65536));
    add_query(make_query(-65536, 2, 0, 0, 0, 65536));
    add_query(make_query(0, 65536, 0, 0, 0, 65536));
    add_query(make_query(0, 65536, -65536, 0, 0, 65536));
    add_query(make_query(0, 65536, -3 * 65536, 0, 0, 65536));
    add_query(make_query(65536, 65536, 0, 0, 0, 2 * 65536));
    add_query(make_query(-65536, -65536, 0, 4096, -4096, 65536));
    add_query(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    add_query(make_query(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h7fffffff));
    add_query(make_query(1, 32'h7fffffff, 0, 32'h7fff0000, 32'h7fff0000,
                         32'h7fffffff));
    add_query(make_query(32'h80000000, 1, 32'h7fffffff, 0, 0, 0));
    add_query(make_query(1, 0, 32'h80000000, 0, 0, 32'h7fffffff));
    add_query(make_query(65536, -65536, 0, 32'h7fff0000, 32'h80010000,
                         32'h7fffffff));
    add_query(make_query(3, 65536, 100, -100, 100, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_tolerance(tol_set[ph]);
      load_random(145);
      drain();
    end

    $display("covered %0d queries, %0d result words: %0d none, %0d tangent, %0d pairs",
             n_queries, n_points, n_none, n_tangent, n_pairs);
    $display("tolerance settings 7, 0, 65535 and %0d; one long output hold-off", tol_set[3]);
    if (n_errors == 0 && expected_points.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
